// ===== rtl/clcd_pkg.sv =====
// ----------------------------------------------------------------------------
// clcd_pkg
// Types and constants shared by the character LCD nibble sender modules.
// ----------------------------------------------------------------------------
`default_nettype none

package clcd_pkg;

  // Command codes of an input item
  localparam logic [1:0] CMD_CHAR   = 2'd0;
  localparam logic [1:0] CMD_RAW    = 2'd1;
  localparam logic [1:0] CMD_CURSOR = 2'd2;
  localparam logic [1:0] CMD_NIBBLE = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] REG_ROWS      = 2'd0;
  localparam logic [1:0] REG_COLUMNS   = 2'd1;
  localparam logic [1:0] REG_BACKLIGHT = 2'd2;
  localparam logic [1:0] REG_ADDRESS   = 2'd3;

  // Configuration reset values
  localparam logic [2:0] ROWS_RESET      = 3'd4;
  localparam logic [5:0] COLUMNS_RESET   = 6'd20;
  localparam logic       BACKLIGHT_RESET = 1'b0;
  localparam logic [6:0] ADDRESS_RESET   = 7'd39;

  // Display command and line start addresses
  localparam logic [7:0] DDRAM_CMD    = 8'h80;
  localparam logic [7:0] LINE0_OFFSET = 8'h00;
  localparam logic [7:0] LINE1_OFFSET = 8'h40;
  localparam logic [7:0] LINE2_OFFSET = 8'h14;
  localparam logic [7:0] LINE3_OFFSET = 8'h54;

  localparam int CFG_DATA_W = 7;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] data_byte;
    logic [1:0] row;
    logic [5:0] column;
  } in_item_t;

  typedef struct packed {
    logic [6:0] bus_address;
    logic [7:0] expander_byte;
    logic       last;
  } out_item_t;

  // One classified job: up to four nibbles, nibbles[0] goes out first
  typedef struct packed {
    logic [3:0][3:0] nibbles;
    logic [3:0]      rs;
    logic [1:0]      last_nib;
  } job_t;

  function automatic logic [7:0] line_offset(input logic [1:0] row);
    logic [7:0] offset;
    unique case (row)
      2'd0:    offset = LINE0_OFFSET;
      2'd1:    offset = LINE1_OFFSET;
      2'd2:    offset = LINE2_OFFSET;
      default: offset = LINE3_OFFSET;
    endcase
    return offset;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/char_lcd_expander_nibble_sender_unit.sv =====
// ----------------------------------------------------------------------------
// char_lcd_expander_nibble_sender_unit
// Character LCD 4-bit driver producing port expander bus writes.
// ----------------------------------------------------------------------------
// Each command item becomes a run of expander bytes: every nibble goes out as
// two bytes, enable high then enable low, so a single nibble gives 2 results,
// a raw command or set cursor gives 4, and a character gives 4, or 8 when the
// cursor wraps to a new line and a set-DDRAM command follows. The front
// accepts one item per cycle while its two-job queue has room; the back
// emits one result per cycle while pop is high, stepping through the bytes
// of each item with its byte sequencer. Last is high on the final result of
// each item. Configuration writes take effect at once and are meant for
// idle periods only.
// ----------------------------------------------------------------------------
`default_nettype none

module char_lcd_expander_nibble_sender_unit #(
  parameter int MAX_COLUMNS = 40,
  parameter int MAX_ROWS    = 4
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  // command side
  input  wire logic                      push,
  output logic                           full,
  input  wire clcd_pkg::in_item_t        item,
  // result side
  output logic                           empty,
  input  wire logic                      pop,
  output clcd_pkg::out_item_t            result,
  // configuration
  input  wire logic                      write_enable,
  input  wire logic [1:0]                reg_index,
  input  wire logic [clcd_pkg::CFG_DATA_W-1:0] write_data
);

  logic [2:0] rows_in_use;
  logic [5:0] columns_in_use;
  logic       backlight_on;
  logic [6:0] expander_address;

  clcd_pkg::job_t front_job;
  clcd_pkg::job_t head_job;
  logic           accept;
  logic           head_valid;
  logic           head_take;

  // Accept an item whenever the job queue has room
  assign accept = push && !full;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use      <= clcd_pkg::ROWS_RESET;
      columns_in_use   <= clcd_pkg::COLUMNS_RESET;
      backlight_on     <= clcd_pkg::BACKLIGHT_RESET;
      expander_address <= clcd_pkg::ADDRESS_RESET;
    end else if (write_enable) begin
      unique case (reg_index)
        clcd_pkg::REG_ROWS:      rows_in_use      <= write_data[2:0];
        clcd_pkg::REG_COLUMNS:   columns_in_use   <= write_data[5:0];
        clcd_pkg::REG_BACKLIGHT: backlight_on     <= write_data[0];
        default:                 expander_address <= write_data[6:0];
      endcase
    end
  end

  // Classify the command and advance the cursor
  clcd_front #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .item           (item),
    .rows_in_use    (rows_in_use),
    .columns_in_use (columns_in_use),
    .job            (front_job)
  );

  // Hold jobs so the front keeps taking items while the back is busy
  clcd_job_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .wr        (accept),
    .wdata     (front_job),
    .rd        (head_take),
    .rdata     (head_job),
    .not_empty (head_valid),
    .full      (full)
  );

  // Emit expander bytes one per cycle while pop is high
  clcd_back u_back (
    .clk              (clk),
    .rst              (rst),
    .head             (head_job),
    .head_valid       (head_valid),
    .head_take        (head_take),
    .pop              (pop),
    .empty            (empty),
    .backlight_on     (backlight_on),
    .expander_address (expander_address),
    .result           (result)
  );

endmodule

`default_nettype wire

// ===== rtl/clcd_front.sv =====
// ----------------------------------------------------------------------------
// clcd_front
// Accept commands, track the cursor and turn each command into a nibble job.
// ----------------------------------------------------------------------------
`default_nettype none

module clcd_front #(
  parameter int MAX_COLUMNS = 40,
  parameter int MAX_ROWS    = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             accept,
  input  wire clcd_pkg::in_item_t item,
  input  wire logic [2:0]       rows_in_use,
  input  wire logic [5:0]       columns_in_use,
  output clcd_pkg::job_t        job
);

  localparam logic [5:0] MaxCols = 6'(MAX_COLUMNS);
  localparam logic [2:0] MaxRows = 3'(MAX_ROWS);

  logic [1:0] cursor_row, cursor_row_next;
  logic [5:0] cursor_column, cursor_column_next;

  logic [5:0] eff_cols;
  logic [2:0] eff_rows;
  logic [6:0] col_inc;
  logic [2:0] row_inc;
  logic       col_wrap;
  logic [1:0] wrap_row;
  logic [1:0] clamp_row;
  logic [5:0] clamp_col;
  logic [7:0] cursor_cmd;
  logic [7:0] wrap_cmd;

  always_comb begin
    // Out-of-range limits act as the nearest legal limit
    if (columns_in_use == 6'd0) begin
      eff_cols = 6'd1;
    end else if (columns_in_use > MaxCols) begin
      eff_cols = MaxCols;
    end else begin
      eff_cols = columns_in_use;
    end
    if (rows_in_use == 3'd0) begin
      eff_rows = 3'd1;
    end else if (rows_in_use > MaxRows) begin
      eff_rows = MaxRows;
    end else begin
      eff_rows = rows_in_use;
    end

    // Character advance
    col_inc  = {1'b0, cursor_column} + 7'd1;
    col_wrap = col_inc >= {1'b0, eff_cols};
    row_inc  = {1'b0, cursor_row} + 3'd1;
    wrap_row = (row_inc >= eff_rows) ? 2'd0 : row_inc[1:0];
    wrap_cmd = clcd_pkg::DDRAM_CMD | clcd_pkg::line_offset(wrap_row);

    // Set cursor clamp
    clamp_col  = (item.column >= eff_cols) ? (eff_cols - 6'd1) : item.column;
    clamp_row  = ({1'b0, item.row} >= eff_rows) ? 2'(eff_rows - 3'd1) : item.row;
    cursor_cmd = clcd_pkg::DDRAM_CMD |
                 ({2'b00, clamp_col} + clcd_pkg::line_offset(clamp_row));

    cursor_row_next    = cursor_row;
    cursor_column_next = cursor_column;
    job.nibbles        = '0;
    job.rs             = '0;
    job.last_nib       = 2'd1;

    unique case (item.command)
      clcd_pkg::CMD_CHAR: begin
        job.nibbles[0] = item.data_byte[7:4];
        job.nibbles[1] = item.data_byte[3:0];
        job.rs         = 4'b0011;
        if (col_wrap) begin
          cursor_row_next    = wrap_row;
          cursor_column_next = 6'd0;
          job.nibbles[2]     = wrap_cmd[7:4];
          job.nibbles[3]     = wrap_cmd[3:0];
          job.last_nib       = 2'd3;
        end else begin
          cursor_column_next = col_inc[5:0];
        end
      end
      clcd_pkg::CMD_RAW: begin
        job.nibbles[0] = item.data_byte[7:4];
        job.nibbles[1] = item.data_byte[3:0];
      end
      clcd_pkg::CMD_CURSOR: begin
        cursor_row_next    = clamp_row;
        cursor_column_next = clamp_col;
        job.nibbles[0]     = cursor_cmd[7:4];
        job.nibbles[1]     = cursor_cmd[3:0];
      end
      default: begin
        job.nibbles[0] = item.data_byte[3:0];
        job.last_nib   = 2'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_row    <= 2'd0;
      cursor_column <= 6'd0;
    end else if (accept) begin
      cursor_row    <= cursor_row_next;
      cursor_column <= cursor_column_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/clcd_job_fifo.sv =====
// ----------------------------------------------------------------------------
// clcd_job_fifo
// Two-entry queue of nibble jobs between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module clcd_job_fifo (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           wr,
  input  wire clcd_pkg::job_t wdata,
  input  wire logic           rd,
  output clcd_pkg::job_t      rdata,
  output logic                not_empty,
  output logic                full
);

  clcd_pkg::job_t entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign rdata     = entries[rd_ptr];
  assign not_empty = count != 2'd0;
  assign full      = count == 2'd2;

  always_ff @(posedge clk) begin
    if (wr) begin
      entries[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr) begin
        wr_ptr <= ~wr_ptr;
      end
      if (rd) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({wr, rd})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/clcd_back.sv =====
// ----------------------------------------------------------------------------
// clcd_back
// Step through a job one expander byte per cycle while pop is high, enable high then low.
// ----------------------------------------------------------------------------
`default_nettype none

module clcd_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire clcd_pkg::job_t head,
  input  wire logic           head_valid,
  output logic                head_take,
  input  wire logic           pop,
  output logic                empty,
  input  wire logic           backlight_on,
  input  wire logic [6:0]     expander_address,
  output clcd_pkg::out_item_t result
);

  clcd_pkg::job_t job;
  logic           valid;
  logic [2:0]     step;

  logic [1:0] nib_idx;
  logic       phase;
  logic       last_byte;

  assign nib_idx   = step[2:1];
  assign phase     = step[0];
  assign last_byte = phase && (nib_idx == job.last_nib);
  assign empty     = ~valid;
  assign head_take = head_valid && (!valid || (pop && last_byte));

  assign result.bus_address   = expander_address;
  assign result.expander_byte = {job.nibbles[nib_idx], backlight_on, ~phase, 1'b0,
                                 job.rs[nib_idx]};
  assign result.last          = last_byte;

  always_ff @(posedge clk) begin
    if (head_take) begin
      job <= head;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      step  <= 3'd0;
    end else if (!valid || (pop && last_byte)) begin
      // load the next job, or drop to idle
      valid <= head_valid;
      step  <= 3'd0;
    end else if (pop) begin
      step <= step + 3'd1;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/clcd_checker.sv =====
// ----------------------------------------------------------------------------
// clcd_checker
// Port-level checks of the nibble sender, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module clcd_checker (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                empty,
  input wire logic                pop,
  input wire clcd_pkg::out_item_t result
);

  // Reset leaves no result waiting
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result waiting right after reset");

  // An enable-high byte is always followed by its enable-low twin
  a_enable_pair: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop && result.expander_byte[2]) |=>
      (!empty && !result.expander_byte[2] &&
       result.expander_byte[7:4] == $past(result.expander_byte[7:4]) &&
       result.expander_byte[0] == $past(result.expander_byte[0])))
    else $error("enable-low byte missing after enable-high byte");

  // The last byte of an item always has enable low, and bit 1 stays clear
  a_last_low: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (!(result.last && result.expander_byte[2]) &&
                !result.expander_byte[1]))
    else $error("bad control bits on result");

  // A waiting result holds until taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(result.expander_byte[7:4]) &&
                          $stable(result.last) && $stable(result.expander_byte[2])))
    else $error("waiting result changed");

endmodule

bind char_lcd_expander_nibble_sender_unit clcd_checker u_checker (
  .clk    (clk),
  .rst    (rst),
  .empty  (empty),
  .pop    (pop),
  .result (result)
);

`default_nettype wire
